### hw/rtl/vtld_pkg.sv
// Vector type decode package: vector register length, decoded field types and
// the type word decode function. No dependencies.
`default_nettype none
package vtld_pkg;

    localparam int unsigned VECTOR_REG_BITS = 128;
    localparam int unsigned VLEN_BITS = $clog2(VECTOR_REG_BITS + 1);
    localparam int unsigned OUT_LEN_W = 8;
    localparam int unsigned EXT_W = (VLEN_BITS > OUT_LEN_W) ? VLEN_BITS : OUT_LEN_W;
    localparam logic [VLEN_BITS-1:0] VLEN_VEC = VLEN_BITS'(VECTOR_REG_BITS);

    localparam logic [2:0] LMUL_RSVD = 3'd4;
    localparam logic [2:0] SEW_SHIFT = 3'd3;

    typedef struct packed {
        logic       legal;
        logic [1:0] code;
        logic [1:0] nlog;
        logic [1:0] dlog;
    } t_type_dec;

    typedef struct packed {
        t_type_dec            req;
        t_type_dec            prev;
        logic                 alen_big;
        logic [VLEN_BITS-1:0] alen_low;
        logic                 eew_ok;
        logic [1:0]           eew_log;
    } t_s1;

    typedef struct packed {
        logic                 req_legal;
        logic [1:0]           code;
        logic [1:0]           nlog;
        logic [1:0]           dlog;
        logic [VLEN_BITS-1:0] req_vlmax;
        logic                 prev_legal;
        logic [VLEN_BITS-1:0] prev_vlmax;
        logic                 alen_big;
        logic [VLEN_BITS-1:0] alen_low;
        logic                 eew_ok;
        logic signed [3:0]    mem_exp;
    } t_s2;

    function automatic t_type_dec decode_word(input logic [63:0] w);
        t_type_dec r;
        logic      lmul_ok;
        r.code  = w[4:3];
        r.nlog  = 2'd0;
        r.dlog  = 2'd0;
        lmul_ok = 1'b1;
        case (w[2:0])
            3'd0, 3'd1, 3'd2, 3'd3: r.nlog = w[1:0];
            3'd5: r.dlog = 2'd3;
            3'd6: r.dlog = 2'd2;
            3'd7: r.dlog = 2'd1;
            LMUL_RSVD: lmul_ok = 1'b0;
            default: lmul_ok = 1'b0;
        endcase
        // SEW must not exceed 64 * LMUL
        r.legal = ~(|w[63:8]) & ~w[5] & lmul_ok &
                  (({1'b0, r.code} + {1'b0, r.dlog}) <= (3'd3 + {1'b0, r.nlog}));
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/vtld_dec_stage.sv
// Stage 1: decodes both type words, the memory element width and the length range.
// Depends on vtld_pkg.
`default_nettype none
module vtld_dec_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [63:0]   i_requested_type,
    input  wire logic [63:0]   i_previous_type,
    input  wire logic [63:0]   i_requested_length,
    input  wire logic [6:0]    i_memory_width,
    output logic               o_valid,
    output vtld_pkg::t_s1      o_data
);

    logic          r_valid;
    vtld_pkg::t_s1 r_data;
    vtld_pkg::t_s1 n_data;

    always_comb begin
        n_data.req      = vtld_pkg::decode_word(i_requested_type);
        n_data.prev     = vtld_pkg::decode_word(i_previous_type);
        n_data.alen_big = |i_requested_length[63:vtld_pkg::VLEN_BITS];
        n_data.alen_low = i_requested_length[vtld_pkg::VLEN_BITS-1:0];
        n_data.eew_ok   = (i_memory_width[2:0] == 3'd0) && $onehot(i_memory_width[6:3]);
        case (i_memory_width[6:3])
            4'b0010: n_data.eew_log = 2'd1;
            4'b0100: n_data.eew_log = 2'd2;
            4'b1000: n_data.eew_log = 2'd3;
            default: n_data.eew_log = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### hw/rtl/vtld_len_stage.sv
// Stage 2: VLMAX for both type words and the effective multiplier exponent.
// Depends on vtld_pkg.
`default_nettype none
module vtld_len_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  vtld_pkg::t_s1      i_data,
    output logic               o_valid,
    output vtld_pkg::t_s2      o_data
);

    logic                           r_valid;
    vtld_pkg::t_s2                  r_data;
    vtld_pkg::t_s2                  n_data;
    logic [vtld_pkg::VLEN_BITS-1:0] req_vl;
    logic [vtld_pkg::VLEN_BITS-1:0] prev_vl;

    always_comb begin
        req_vl  = ((vtld_pkg::VLEN_VEC >> ({1'b0, i_data.req.code} + vtld_pkg::SEW_SHIFT))
                   << i_data.req.nlog) >> i_data.req.dlog;
        prev_vl = ((vtld_pkg::VLEN_VEC >> ({1'b0, i_data.prev.code} + vtld_pkg::SEW_SHIFT))
                   << i_data.prev.nlog) >> i_data.prev.dlog;
        n_data.req_legal  = i_data.req.legal && (req_vl != '0);
        n_data.code       = i_data.req.code;
        n_data.nlog       = i_data.req.nlog;
        n_data.dlog       = i_data.req.dlog;
        n_data.req_vlmax  = req_vl;
        n_data.prev_legal = i_data.prev.legal && (prev_vl != '0);
        n_data.prev_vlmax = prev_vl;
        n_data.alen_big   = i_data.alen_big;
        n_data.alen_low   = i_data.alen_low;
        n_data.eew_ok     = i_data.eew_ok;
        // log2(EMUL) = log2(EEW/SEW) + log2(LMUL)
        n_data.mem_exp    = $signed({2'b00, i_data.req.nlog}) - $signed({2'b00, i_data.req.dlog})
                          + $signed({2'b00, i_data.eew_log}) - $signed({2'b00, i_data.req.code});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### hw/rtl/vtld_out_stage.sv
// Stage 3: granted length, keep-length flag, memory multiplier and result registers.
// Depends on vtld_pkg.
`default_nettype none
module vtld_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  vtld_pkg::t_s2      i_data,
    output logic               o_strobe,
    output logic               o_type_legal,
    output logic [6:0]         o_element_bits,
    output logic [3:0]         o_group_numerator,
    output logic [3:0]         o_group_denominator,
    output logic [7:0]         o_max_length,
    output logic [7:0]         o_granted_length,
    output logic               o_keeps_length,
    output logic               o_memory_legal,
    output logic [3:0]         o_memory_numerator,
    output logic [3:0]         o_memory_denominator
);

    logic                           r_strobe;
    logic                           r_type_legal;
    logic [6:0]                     r_element_bits;
    logic [3:0]                     r_group_numerator;
    logic [3:0]                     r_group_denominator;
    logic [7:0]                     r_max_length;
    logic [7:0]                     r_granted_length;
    logic                           r_keeps_length;
    logic                           r_memory_legal;
    logic [3:0]                     r_memory_numerator;
    logic [3:0]                     r_memory_denominator;
    logic [vtld_pkg::VLEN_BITS-1:0] grant;
    logic [vtld_pkg::EXT_W-1:0]     vl_ext;
    logic [vtld_pkg::EXT_W-1:0]     gr_ext;
    logic signed [3:0]              neg_exp;
    logic                           mem_ok;
    logic                           lg;

    always_comb begin
        lg      = i_data.req_legal;
        grant   = (i_data.alen_big || (i_data.alen_low >= i_data.req_vlmax)) ?
                  i_data.req_vlmax : i_data.alen_low;
        vl_ext  = vtld_pkg::EXT_W'(i_data.req_vlmax);
        gr_ext  = vtld_pkg::EXT_W'(grant);
        neg_exp = -i_data.mem_exp;
        mem_ok  = lg && i_data.eew_ok &&
                  (i_data.mem_exp >= -4'sd3) && (i_data.mem_exp <= 4'sd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
        r_type_legal        <= lg;
        r_element_bits      <= lg ? (7'd8 << i_data.code) : 7'd0;
        r_group_numerator   <= lg ? (4'd1 << i_data.nlog) : 4'd0;
        r_group_denominator <= lg ? (4'd1 << i_data.dlog) : 4'd0;
        r_max_length        <= lg ? vl_ext[7:0] : 8'd0;
        r_granted_length    <= lg ? gr_ext[7:0] : 8'd0;
        r_keeps_length      <= lg && i_data.prev_legal &&
                               (i_data.req_vlmax == i_data.prev_vlmax);
        r_memory_legal      <= mem_ok;
        if (!mem_ok) begin
            r_memory_numerator   <= 4'd0;
            r_memory_denominator <= 4'd0;
        end else if (i_data.mem_exp >= 4'sd0) begin
            r_memory_numerator   <= 4'd1 << i_data.mem_exp[1:0];
            r_memory_denominator <= 4'd1;
        end else begin
            r_memory_numerator   <= 4'd1;
            r_memory_denominator <= 4'd1 << neg_exp[1:0];
        end
    end

    assign o_strobe             = r_strobe;
    assign o_type_legal         = r_type_legal;
    assign o_element_bits       = r_element_bits;
    assign o_group_numerator    = r_group_numerator;
    assign o_group_denominator  = r_group_denominator;
    assign o_max_length         = r_max_length;
    assign o_granted_length     = r_granted_length;
    assign o_keeps_length       = r_keeps_length;
    assign o_memory_legal       = r_memory_legal;
    assign o_memory_numerator   = r_memory_numerator;
    assign o_memory_denominator = r_memory_denominator;

endmodule
`default_nettype wire

### hw/rtl/vector_type_decode_and_length_select_top.sv
// Top level of the vector type decoder: three register stages, decode, length, output.
// Depends on vtld_pkg, vtld_dec_stage, vtld_len_stage, vtld_out_stage.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------------
//  command  | start, busy      | i_requested_type, i_previous_type,
//           |                  | i_requested_length, i_memory_width
//  result   | o_strobe         | o_type_legal .. o_memory_denominator
//
// One beat in per cycle; busy stays low. After its beat is taken, a result passes one
// pipeline register per stage (decode, VLMAX, output select) before it appears.
// Synchronous active-low reset clears the stage valid bits only.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module vector_type_decode_and_length_select_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_requested_type,
    input  wire logic [63:0] i_previous_type,
    input  wire logic [63:0] i_requested_length,
    input  wire logic [6:0]  i_memory_width,
    output logic             o_strobe,
    output logic             o_type_legal,
    output logic [6:0]       o_element_bits,
    output logic [3:0]       o_group_numerator,
    output logic [3:0]       o_group_denominator,
    output logic [7:0]       o_max_length,
    output logic [7:0]       o_granted_length,
    output logic             o_keeps_length,
    output logic             o_memory_legal,
    output logic [3:0]       o_memory_numerator,
    output logic [3:0]       o_memory_denominator
);

    logic          s1_valid;
    vtld_pkg::t_s1 s1_data;
    logic          s2_valid;
    vtld_pkg::t_s2 s2_data;

    assign busy = 1'b0;

    vtld_dec_stage u_dec (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (start & ~busy),
        .i_requested_type   (i_requested_type),
        .i_previous_type    (i_previous_type),
        .i_requested_length (i_requested_length),
        .i_memory_width     (i_memory_width),
        .o_valid            (s1_valid),
        .o_data             (s1_data)
    );

    vtld_len_stage u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    vtld_out_stage u_out (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (s2_valid),
        .i_data               (s2_data),
        .o_strobe             (o_strobe),
        .o_type_legal         (o_type_legal),
        .o_element_bits       (o_element_bits),
        .o_group_numerator    (o_group_numerator),
        .o_group_denominator  (o_group_denominator),
        .o_max_length         (o_max_length),
        .o_granted_length     (o_granted_length),
        .o_keeps_length       (o_keeps_length),
        .o_memory_legal       (o_memory_legal),
        .o_memory_numerator   (o_memory_numerator),
        .o_memory_denominator (o_memory_denominator)
    );

endmodule
`default_nettype wire

### hw/rtl/vtld_checker.sv
// Port-level checks for the vector type decoder, bound to the top level.
// Depends on vector_type_decode_and_length_select_top.
`default_nettype none
module vtld_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic       o_type_legal,
    input wire logic [6:0] o_element_bits,
    input wire logic [7:0] o_max_length,
    input wire logic [7:0] o_granted_length,
    input wire logic       o_keeps_length,
    input wire logic       o_memory_legal,
    input wire logic [3:0] o_memory_numerator,
    input wire logic [3:0] o_memory_denominator
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_strobe)
        else $error("beat taken without result three cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 3))
        else $error("result without a beat");

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_type_legal) |-> (o_element_bits == 7'd0 && o_max_length == 8'd0 &&
        o_granted_length == 8'd0 && !o_keeps_length && !o_memory_legal))
        else $error("illegal type with non-zero fields");

    a_grant_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_type_legal) |-> (o_granted_length <= o_max_length))
        else $error("granted length above VLMAX");

    a_emul_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_memory_legal) |-> ($onehot(o_memory_numerator) &&
        $onehot(o_memory_denominator) &&
        (o_memory_numerator == 4'd1 || o_memory_denominator == 4'd1)))
        else $error("memory multiplier not reduced");

endmodule

bind vector_type_decode_and_length_select_top vtld_checker u_vtld_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .start                (start),
    .busy                 (busy),
    .o_strobe             (o_strobe),
    .o_type_legal         (o_type_legal),
    .o_element_bits       (o_element_bits),
    .o_max_length         (o_max_length),
    .o_granted_length     (o_granted_length),
    .o_keeps_length       (o_keeps_length),
    .o_memory_legal       (o_memory_legal),
    .o_memory_numerator   (o_memory_numerator),
    .o_memory_denominator (o_memory_denominator)
);
`default_nettype wire

### sim/vector_type_decode_and_length_select_top_test.sv
`timescale 1ns / 1ps
// Testbench for the vector type decoder: directed and random command beats, result
// checking against a type/length/EMUL decoder kept here. Depends on vtld_pkg and the top.
module vector_type_decode_and_length_select_top_test;

    localparam logic [2:0] LMUL_EIGHTH  = 3'd5;
    localparam logic [2:0] LMUL_QUARTER = 3'd6;
    localparam logic [2:0] LMUL_HALF    = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned BEATS_PER_PHASE = 570;

    typedef struct {
        bit       type_legal;
        bit [6:0] element_bits;
        bit [3:0] group_numerator;
        bit [3:0] group_denominator;
        bit [7:0] max_length;
        bit [7:0] granted_length;
        bit       keeps_length;
        bit       memory_legal;
        bit [3:0] memory_numerator;
        bit [3:0] memory_denominator;
    } t_vtype_result;

    class t_vtype_tracker;
        t_vtype_result decodes_due[$];
        int unsigned   errors;

        function new();
            errors = 0;
        endfunction

        function int unsigned pending();
            return decodes_due.size();
        endfunction

        function void decode_vtype(input bit [63:0] w, output bit ok,
                                   output int unsigned sew, output int unsigned num,
                                   output int unsigned den, output int unsigned vlmax);
            int unsigned s, n, d, v;
            ok = 0; sew = 0; num = 0; den = 0; vlmax = 0;
            if (w[63:8] != 0 || w[5:3] > 3)
                return;
            s = 8 << w[5:3];
            n = 1;
            d = 1;
            case (w[2:0])
                LMUL_EIGHTH:         d = 8;
                LMUL_QUARTER:        d = 4;
                LMUL_HALF:           d = 2;
                vtld_pkg::LMUL_RSVD: return;
                default:             n = 1 << w[1:0];
            endcase
            if (s > (64 * n) / d)
                return;
            v = ((vtld_pkg::VECTOR_REG_BITS / s) * n) / d;
            if (v == 0)
                return;
            ok = 1; sew = s; num = n; den = d; vlmax = v;
        endfunction

        function void note_command(bit [63:0] rt, bit [63:0] pt, bit [63:0] rl, bit [6:0] mw);
            t_vtype_result r;
            bit            ok_r, ok_p;
            int unsigned   sew_r, num_r, den_r, vl_r, sew_p, num_p, den_p, vl_p;
            int unsigned   n, d;
            bit [63:0]     granted;
            decode_vtype(rt, ok_r, sew_r, num_r, den_r, vl_r);
            decode_vtype(pt, ok_p, sew_p, num_p, den_p, vl_p);
            granted = 0;
            if (ok_r)
                granted = (rl < 64'(vl_r)) ? rl : 64'(vl_r);
            r.type_legal        = ok_r;
            r.element_bits      = sew_r[6:0];
            r.group_numerator   = num_r[3:0];
            r.group_denominator = den_r[3:0];
            r.max_length        = vl_r[7:0];
            r.granted_length    = granted[7:0];
            r.keeps_length      = ok_r && ok_p && vl_r == vl_p;
            r.memory_legal      = 0;
            r.memory_numerator  = 0;
            r.memory_denominator = 0;
            if (ok_r && mw >= 8 && mw <= 64 && (mw & (mw - 7'd1)) == 0) begin
                n = num_r * mw;
                d = den_r * sew_r;
                for (int i = 0; i < 16 && n[0] == 0 && d[0] == 0; i++) begin
                    n = n >> 1;
                    d = d >> 1;
                end
                if ((d == 1 && (n == 1 || n == 2 || n == 4 || n == 8)) ||
                    (n == 1 && (d == 2 || d == 4 || d == 8))) begin
                    r.memory_legal       = 1;
                    r.memory_numerator   = n[3:0];
                    r.memory_denominator = d[3:0];
                end
            end
            decodes_due.push_back(r);
        endfunction

        function void check_field(string name, bit [7:0] exp_v, bit [7:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_vtype_result got);
            t_vtype_result e;
            if (decodes_due.size() == 0) begin
                $display("%0t: result with none due, expected nothing actual legal=%0d len=%0d",
                         $time, got.type_legal, got.granted_length);
                errors++;
                return;
            end
            e = decodes_due.pop_front();
            check_field("type_legal", e.type_legal, got.type_legal);
            check_field("element_bits", e.element_bits, got.element_bits);
            check_field("group_numerator", e.group_numerator, got.group_numerator);
            check_field("group_denominator", e.group_denominator, got.group_denominator);
            check_field("max_length", e.max_length, got.max_length);
            check_field("granted_length", e.granted_length, got.granted_length);
            check_field("keeps_length", e.keeps_length, got.keeps_length);
            check_field("memory_legal", e.memory_legal, got.memory_legal);
            check_field("memory_numerator", e.memory_numerator, got.memory_numerator);
            check_field("memory_denominator", e.memory_denominator, got.memory_denominator);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_requested_type;
    logic [63:0] i_previous_type;
    logic [63:0] i_requested_length;
    logic [6:0]  i_memory_width;
    logic        o_strobe;
    logic        o_type_legal;
    logic [6:0]  o_element_bits;
    logic [3:0]  o_group_numerator;
    logic [3:0]  o_group_denominator;
    logic [7:0]  o_max_length;
    logic [7:0]  o_granted_length;
    logic        o_keeps_length;
    logic        o_memory_legal;
    logic [3:0]  o_memory_numerator;
    logic [3:0]  o_memory_denominator;

    t_vtype_tracker tracker = new();
    t_vtype_result  seen;
    int unsigned    beats_taken = 0;
    int unsigned    cycle_count = 0;

    vector_type_decode_and_length_select_top u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_requested_type     (i_requested_type),
        .i_previous_type      (i_previous_type),
        .i_requested_length   (i_requested_length),
        .i_memory_width       (i_memory_width),
        .o_strobe             (o_strobe),
        .o_type_legal         (o_type_legal),
        .o_element_bits       (o_element_bits),
        .o_group_numerator    (o_group_numerator),
        .o_group_denominator  (o_group_denominator),
        .o_max_length         (o_max_length),
        .o_granted_length     (o_granted_length),
        .o_keeps_length       (o_keeps_length),
        .o_memory_legal       (o_memory_legal),
        .o_memory_numerator   (o_memory_numerator),
        .o_memory_denominator (o_memory_denominator)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // beats and results seen at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                tracker.note_command(i_requested_type, i_previous_type,
                                     i_requested_length, i_memory_width);
                beats_taken++;
            end
            if (o_strobe) begin
                seen.type_legal         = o_type_legal;
                seen.element_bits       = o_element_bits;
                seen.group_numerator    = o_group_numerator;
                seen.group_denominator  = o_group_denominator;
                seen.max_length         = o_max_length;
                seen.granted_length     = o_granted_length;
                seen.keeps_length       = o_keeps_length;
                seen.memory_legal       = o_memory_legal;
                seen.memory_numerator   = o_memory_numerator;
                seen.memory_denominator = o_memory_denominator;
                tracker.check_result(seen);
            end
        end
    end

    function automatic bit [63:0] random_vtype();
        bit [63:0] w;
        w = {56'd0, 8'($urandom)};
        case ($urandom_range(9))
            6, 7:    w[5] = 1'b0;
            8:       w = {$urandom, $urandom};
            9:       w[$urandom_range(63, 8)] = 1'b1;
            default: ;
        endcase
        return w;
    endfunction

    function automatic bit [63:0] random_length();
        case ($urandom_range(7))
            6:       return {$urandom, $urandom};
            7:       return 64'($urandom_range(140, 120));
            default: return 64'($urandom_range(200));
        endcase
    endfunction

    function automatic bit [6:0] random_memory_width();
        if ($urandom_range(1))
            return 7'd8 << $urandom_range(3);
        return 7'($urandom_range(127));
    endfunction

    task automatic send_command(bit [63:0] rt, bit [63:0] pt, bit [63:0] rl, bit [6:0] mw);
        int unsigned target;
        @(negedge i_clk);
        start              = 1'b1;
        i_requested_type   = rt;
        i_previous_type    = pt;
        i_requested_length = rl;
        i_memory_width     = mw;
        target = beats_taken + 1;
        wait (beats_taken >= target);
    endtask

    task automatic idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start              = 1'b0;
            i_requested_type   = random_vtype();
            i_previous_type    = random_vtype();
            i_requested_length = random_length();
            i_memory_width     = random_memory_width();
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned idle_pct;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_requested_type   = '0;
        i_previous_type    = '0;
        i_requested_length = '0;
        i_memory_width     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_command(64'h00, 64'h00, 64'd0, 7'd8);
        send_command(64'h1B, 64'h00, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_command(64'h19, 64'h1B, 64'd129, 7'd32);
        send_command(64'h1D, 64'h05, 64'd1, 7'd8);
        send_command(64'h05, 64'h1D, 64'd1, 7'd8);
        send_command(64'h05, 64'h0E, 64'd127, 7'd64);
        send_command(64'h06, 64'h07, 64'd16, 7'd16);
        send_command(64'h07, 64'h06, 64'd128, 7'd32);
        send_command(64'h04, 64'h00, 64'd5, 7'd8);
        send_command(64'h20, 64'h20, 64'd5, 7'd16);
        send_command(64'h38, 64'h00, 64'd5, 7'd16);
        send_command(64'hC0, 64'h00, 64'd200, 7'd127);
        send_command(64'h100, 64'h00, 64'd3, 7'd8);
        send_command(64'h8000_0000_0000_0000, 64'h00, 64'd3, 7'd8);
        send_command(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 7'd127);
        send_command(64'h0E, 64'h8000_0000_0000_0000, 64'd2, 7'd8);
        send_command(64'h16, 64'h0E, 64'd2, 7'd16);
        send_command(64'h1F, 64'h0F, 64'd2, 7'd64);
        send_command(64'h02, 64'h0B, 64'd40, 7'd64);
        send_command(64'h03, 64'h13, 64'd128, 7'd8);
        send_command(64'h13, 64'h03, 64'd0, 7'd0);
        send_command(64'h0B, 64'h02, 64'd8, 7'd9);
        send_command(64'h12, 64'h01, 64'd8, 7'd4);
        send_command(64'h1B, 64'h18, 64'hFFFF_FFFF_FFFF_FF80, 7'd8);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 10 : (phase == 1) ? 59 : 0;
            repeat (BEATS_PER_PHASE) begin
                while ($urandom_range(99) < idle_pct)
                    idle_cycles(1);
                send_command(random_vtype(), random_vtype(), random_length(),
                             random_memory_width());
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### vector_type_decode_and_length_select_top.f
hw/rtl/vtld_pkg.sv
hw/rtl/vtld_dec_stage.sv
hw/rtl/vtld_len_stage.sv
hw/rtl/vtld_out_stage.sv
hw/rtl/vector_type_decode_and_length_select_top.sv
hw/rtl/vtld_checker.sv
sim/vector_type_decode_and_length_select_top_test.sv
